@@ rtl/ttd_pkg.sv @@
// Shared constants, register indexes and helper functions for the
// time/space-to-depth address generator. No dependencies.

package ttd_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BATCHES    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_TIME   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_FOLD  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_FOLD = 3'd6;

   // Field widths of the configuration registers.
   localparam int SIZE_W     = 16;
   localparam int FOLD_W     = 5;
   localparam int FOLD_CNT_W = 4;

   // Loop levels, ordered by their weight in the source offset.
   localparam int NUM_LEVELS = 8;
   localparam int LEVEL_W    = 3;

   localparam logic [LEVEL_W-1:0] LVL_CHAN  = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_WFOLD = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_WOUT  = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_HFOLD = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_HOUT  = 3'd4;
   localparam logic [LEVEL_W-1:0] LVL_TFOLD = 3'd5;
   localparam logic [LEVEL_W-1:0] LVL_TOUT  = 3'd6;
   localparam logic [LEVEL_W-1:0] LVL_BATCH = 3'd7;

   // Stride recompute operations. Bit 3 selects a term product, the low
   // bits select the level.
   localparam int OP_W = 4;

   localparam logic [OP_W-1:0] OP_FIRST_STRIDE = 4'd0;
   localparam logic [OP_W-1:0] OP_LAST_STRIDE  = 4'd6;
   localparam logic [OP_W-1:0] OP_FIRST_TERM   = 4'd8;
   localparam logic [OP_W-1:0] OP_LAST_TERM    = 4'd15;

   // Last counter value for a fold factor: zero acts as one, above
   // sixteen acts as sixteen.
   function automatic logic [FOLD_CNT_W-1:0] fold_lim(input logic [FOLD_W-1:0] v);
      logic [FOLD_W-1:0] m;
      m = v - FOLD_W'(1);
      if (v == '0) begin
         return '0;
      end else if (v > FOLD_W'(16)) begin
         return '1;
      end
      return m[FOLD_CNT_W-1:0];
   endfunction

endpackage

@@ rtl/ttd_if.sv @@
// Channel interfaces of the address generator: walk request, offset
// result and configuration write. Depends on ttd_pkg.

interface ttd_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface ttd_rsp_if #(parameter int OFFSET_WIDTH = 48);
   logic                    valid;
   logic                    ready;
   logic [OFFSET_WIDTH-1:0] src_offset;
   logic [OFFSET_WIDTH-1:0] dst_offset;
   logic                    segment_end;
   logic                    last;

   modport source (output valid, output src_offset, output dst_offset,
                   output segment_end, output last, input ready);
   modport sink (input valid, input src_offset, input dst_offset,
                 input segment_end, input last, output ready);
endinterface

interface ttd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ttd_pkg::CSR_INDEX_W-1:0] index;
   logic [ttd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ttd_serial_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, used to
// rebuild strides and offset terms after a configuration write. No dependencies.

module ttd_serial_mul #(
   parameter int A_WIDTH = 48,
   parameter int B_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_WIDTH-1:0] a,
   input  logic [B_WIDTH-1:0] b,
   input  logic [A_WIDTH-1:0] acc_init,
   output logic               done,
   output logic [A_WIDTH-1:0] product
);

   logic               busy_ff;
   logic               done_ff;
   logic [A_WIDTH-1:0] a_ff;
   logic [B_WIDTH-1:0] b_ff;
   logic [A_WIDTH-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && b_ff == '0) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   // The product is acc_init + a * b modulo 2^A_WIDTH; the loop ends as
   // soon as no multiplier bits remain.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= acc_init;
      end else if (busy_ff && b_ff != '0) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/timespace_to_depth_address_gen.sv @@
// Top level of the time/space-to-depth address generator.
// Depends on ttd_pkg, ttd_if (channel interfaces) and ttd_serial_mul.
//
// Usage:
//   req_bus carries one request per transfer; restart = 1 clears the walk
//   and returns element zero, restart = 0 returns the next element.
//   rsp_bus returns one source/destination offset pair per request, with
//   segment_end on the last channel of a cell and last on the final
//   element of the tensor, after which the walk wraps to element zero.
//   csr_bus writes one shape register per transfer and is always ready.
// Timing:
//   One request is taken every cycle while req_bus.ready is high. The
//   source offset goes through a registered adder tree: pair sums, quad
//   sums, then the final sum in the output register.
//   After every configuration write the strides and the offset terms of
//   the current counters are rebuilt by one shared bit-serial multiplier,
//   15 products in turn; req_bus.ready stays low during that time.
//   Reset clears the counters, sets every register to one and leaves the
//   block ready at once. When rsp_bus stalls, the three stages fill and
//   req_bus.ready then drops until the output is taken.

module timespace_to_depth_address_gen #(
   parameter int OFFSET_WIDTH = 48,
   parameter int COUNT_WIDTH  = 16
) (
   input logic            clock,
   input logic            reset,
   ttd_req_if.sink        req_bus,
   ttd_rsp_if.source      rsp_bus,
   ttd_csr_if.sink        csr_bus
);

   localparam int NL = ttd_pkg::NUM_LEVELS;
   localparam int SW = (COUNT_WIDTH + 1 > ttd_pkg::SIZE_W + 1) ?
                       COUNT_WIDTH + 1 : ttd_pkg::SIZE_W + 1;

   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'b001,
      SEQ_ISSUE = 3'b010,
      SEQ_WAIT  = 3'b100
   } seq_state_type;

   // Last counter value for a size register: zero acts as one and the size
   // is capped at 2^COUNT_WIDTH.
   function automatic logic [COUNT_WIDTH-1:0] size_lim(
      input logic [ttd_pkg::SIZE_W-1:0] v);
      logic [SW-1:0] ext;
      logic [SW-1:0] cap;
      logic [SW-1:0] eff;
      ext = SW'(v);
      cap = SW'(1) << COUNT_WIDTH;
      if (ext == '0) begin
         eff = SW'(1);
      end else if (ext > cap) begin
         eff = cap;
      end else begin
         eff = ext;
      end
      eff = eff - SW'(1);
      return eff[COUNT_WIDTH-1:0];
   endfunction

   // ---------------------------------------------------------------
   // Configuration, held as last counter values.
   // ---------------------------------------------------------------
   logic [COUNT_WIDTH-1:0]         batch_lim_ff;
   logic [COUNT_WIDTH-1:0]         tout_lim_ff;
   logic [COUNT_WIDTH-1:0]         hout_lim_ff;
   logic [COUNT_WIDTH-1:0]         wout_lim_ff;
   logic [COUNT_WIDTH-1:0]         chan_lim_ff;
   logic [ttd_pkg::FOLD_CNT_W-1:0] tfold_lim_ff;
   logic [ttd_pkg::FOLD_CNT_W-1:0] sfold_lim_ff;
   logic                           csr_fire;

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid & csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_lim_ff <= '0;
         tout_lim_ff  <= '0;
         hout_lim_ff  <= '0;
         wout_lim_ff  <= '0;
         chan_lim_ff  <= '0;
         tfold_lim_ff <= '0;
         sfold_lim_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_bus.index)
            ttd_pkg::CSR_BATCHES:    batch_lim_ff <= size_lim(csr_bus.data);
            ttd_pkg::CSR_OUT_TIME:   tout_lim_ff  <= size_lim(csr_bus.data);
            ttd_pkg::CSR_OUT_HEIGHT: hout_lim_ff  <= size_lim(csr_bus.data);
            ttd_pkg::CSR_OUT_WIDTH:  wout_lim_ff  <= size_lim(csr_bus.data);
            ttd_pkg::CSR_CHANNELS:   chan_lim_ff  <= size_lim(csr_bus.data);
            ttd_pkg::CSR_TIME_FOLD:
               tfold_lim_ff <= ttd_pkg::fold_lim(csr_bus.data[ttd_pkg::FOLD_W-1:0]);
            ttd_pkg::CSR_SPACE_FOLD:
               sfold_lim_ff <= ttd_pkg::fold_lim(csr_bus.data[ttd_pkg::FOLD_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   logic [COUNT_WIDTH-1:0] lim_arr [NL];

   always_comb begin
      lim_arr[ttd_pkg::LVL_CHAN]  = chan_lim_ff;
      lim_arr[ttd_pkg::LVL_WFOLD] = COUNT_WIDTH'(sfold_lim_ff);
      lim_arr[ttd_pkg::LVL_WOUT]  = wout_lim_ff;
      lim_arr[ttd_pkg::LVL_HFOLD] = COUNT_WIDTH'(sfold_lim_ff);
      lim_arr[ttd_pkg::LVL_HOUT]  = hout_lim_ff;
      lim_arr[ttd_pkg::LVL_TFOLD] = COUNT_WIDTH'(tfold_lim_ff);
      lim_arr[ttd_pkg::LVL_TOUT]  = tout_lim_ff;
      lim_arr[ttd_pkg::LVL_BATCH] = batch_lim_ff;
   end

   // ---------------------------------------------------------------
   // Walk state: one counter per level, its weighted term of the source
   // offset, and the stride of each level.
   // ---------------------------------------------------------------
   logic [COUNT_WIDTH-1:0]  cnt_ff    [NL];
   logic [COUNT_WIDTH-1:0]  cnt_in    [NL];
   logic [COUNT_WIDTH-1:0]  cnt_snap  [NL];
   logic [OFFSET_WIDTH-1:0] term_ff   [NL];
   logic [OFFSET_WIDTH-1:0] term_in   [NL];
   logic [OFFSET_WIDTH-1:0] term_snap [NL];
   logic [OFFSET_WIDTH-1:0] stride_ff [NL];
   logic [OFFSET_WIDTH-1:0] dst_ff;
   logic [OFFSET_WIDTH-1:0] dst_snap;
   logic [OFFSET_WIDTH-1:0] dst_in;
   logic [NL-1:0]           at_last;
   logic [NL-1:0]           tick_en;
   logic                    seg_end_w;
   logic                    last_w;
   logic                    cnt_zero_w;
   logic                    accept;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         cnt_snap[i]  = req_bus.restart ? '0 : cnt_ff[i];
         term_snap[i] = req_bus.restart ? '0 : term_ff[i];
         at_last[i]   = cnt_snap[i] >= lim_arr[i];
      end

      // Carry chain in walk order: channel, width fold, height fold, time
      // fold, then output width, height, time and batch.
      tick_en[ttd_pkg::LVL_CHAN]  = 1'b1;
      tick_en[ttd_pkg::LVL_WFOLD] = at_last[ttd_pkg::LVL_CHAN];
      tick_en[ttd_pkg::LVL_HFOLD] = tick_en[ttd_pkg::LVL_WFOLD] & at_last[ttd_pkg::LVL_WFOLD];
      tick_en[ttd_pkg::LVL_TFOLD] = tick_en[ttd_pkg::LVL_HFOLD] & at_last[ttd_pkg::LVL_HFOLD];
      tick_en[ttd_pkg::LVL_WOUT]  = tick_en[ttd_pkg::LVL_TFOLD] & at_last[ttd_pkg::LVL_TFOLD];
      tick_en[ttd_pkg::LVL_HOUT]  = tick_en[ttd_pkg::LVL_WOUT] & at_last[ttd_pkg::LVL_WOUT];
      tick_en[ttd_pkg::LVL_TOUT]  = tick_en[ttd_pkg::LVL_HOUT] & at_last[ttd_pkg::LVL_HOUT];
      tick_en[ttd_pkg::LVL_BATCH] = tick_en[ttd_pkg::LVL_TOUT] & at_last[ttd_pkg::LVL_TOUT];

      seg_end_w = at_last[ttd_pkg::LVL_CHAN];
      last_w    = tick_en[ttd_pkg::LVL_BATCH] & at_last[ttd_pkg::LVL_BATCH];

      for (int i = 0; i < NL; i++) begin
         if (tick_en[i] && at_last[i]) begin
            cnt_in[i]  = '0;
            term_in[i] = '0;
         end else if (tick_en[i]) begin
            cnt_in[i]  = cnt_snap[i] + COUNT_WIDTH'(1);
            term_in[i] = term_snap[i] + stride_ff[i];
         end else begin
            cnt_in[i]  = cnt_snap[i];
            term_in[i] = term_snap[i];
         end
      end

      dst_snap = req_bus.restart ? '0 : dst_ff;
      dst_in   = last_w ? '0 : dst_snap + OFFSET_WIDTH'(1);

      cnt_zero_w = 1'b1;
      for (int i = 0; i < NL; i++) begin
         if (cnt_ff[i] != '0) begin
            cnt_zero_w = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Recompute sequencer: strides first, then the term of each level
   // for the counters as held.
   // ---------------------------------------------------------------
   seq_state_type               seq_state_ff;
   logic [ttd_pkg::OP_W-1:0]    op_ff;
   logic [ttd_pkg::LEVEL_W-1:0] op_lvl;
   logic                        op_is_term;
   logic                        mul_start;
   logic [COUNT_WIDTH-1:0]      mul_b;
   logic [OFFSET_WIDTH-1:0]     mul_acc_init;
   logic                        mul_done;
   logic [OFFSET_WIDTH-1:0]     mul_product;
   logic                        seq_wr;

   assign op_lvl     = op_ff[ttd_pkg::LEVEL_W-1:0];
   assign op_is_term = op_ff[ttd_pkg::OP_W-1];
   assign mul_start  = (seq_state_ff == SEQ_ISSUE);
   assign seq_wr     = (seq_state_ff == SEQ_WAIT) & mul_done;

   // A stride product is stride * (last + 1), so the accumulator starts
   // at the stride itself.
   assign mul_b        = op_is_term ? cnt_ff[op_lvl] : lim_arr[op_lvl];
   assign mul_acc_init = op_is_term ? '0 : stride_ff[op_lvl];

   ttd_serial_mul #(
      .A_WIDTH (OFFSET_WIDTH),
      .B_WIDTH (COUNT_WIDTH)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .a        (stride_ff[op_lvl]),
      .b        (mul_b),
      .acc_init (mul_acc_init),
      .done     (mul_done),
      .product  (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= SEQ_IDLE;
         op_ff        <= ttd_pkg::OP_FIRST_STRIDE;
      end else if (csr_fire) begin
         seq_state_ff <= SEQ_ISSUE;
         op_ff        <= ttd_pkg::OP_FIRST_STRIDE;
      end else begin
         unique case (seq_state_ff)
            SEQ_IDLE: begin
            end
            SEQ_ISSUE: seq_state_ff <= SEQ_WAIT;
            SEQ_WAIT: begin
               if (mul_done) begin
                  if (op_ff == ttd_pkg::OP_LAST_TERM) begin
                     seq_state_ff <= SEQ_IDLE;
                  end else if (op_ff == ttd_pkg::OP_LAST_STRIDE) begin
                     seq_state_ff <= SEQ_ISSUE;
                     op_ff        <= ttd_pkg::OP_FIRST_TERM;
                  end else begin
                     seq_state_ff <= SEQ_ISSUE;
                     op_ff        <= op_ff + ttd_pkg::OP_W'(1);
                  end
               end
            end
            default: seq_state_ff <= SEQ_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            stride_ff[i] <= OFFSET_WIDTH'(1);
         end
      end else if (seq_wr && !op_is_term) begin
         stride_ff[op_lvl + ttd_pkg::LEVEL_W'(1)] <= mul_product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            cnt_ff[i]  <= '0;
            term_ff[i] <= '0;
         end
         dst_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < NL; i++) begin
            cnt_ff[i]  <= cnt_in[i];
            term_ff[i] <= term_in[i];
         end
         dst_ff <= dst_in;
      end else if (seq_wr && op_is_term) begin
         term_ff[op_lvl] <= mul_product;
      end
   end

   // ---------------------------------------------------------------
   // Result pipeline: pair sums, quad sums, final sum in the output
   // register.
   // ---------------------------------------------------------------
   logic                    a_valid_ff;
   logic [OFFSET_WIDTH-1:0] a_sum_ff [4];
   logic [OFFSET_WIDTH-1:0] a_dst_ff;
   logic                    a_seg_ff;
   logic                    a_last_ff;
   logic                    b_valid_ff;
   logic [OFFSET_WIDTH-1:0] b_sum_ff [2];
   logic [OFFSET_WIDTH-1:0] b_dst_ff;
   logic                    b_seg_ff;
   logic                    b_last_ff;
   logic                    c_valid_ff;
   logic [OFFSET_WIDTH-1:0] c_src_ff;
   logic [OFFSET_WIDTH-1:0] c_dst_ff;
   logic                    c_seg_ff;
   logic                    c_last_ff;
   logic                    move_a;
   logic                    move_b;
   logic                    move_c;

   assign move_c = ~c_valid_ff | rsp_bus.ready;
   assign move_b = ~b_valid_ff | move_c;
   assign move_a = ~a_valid_ff | move_b;

   assign req_bus.ready = move_a & (seq_state_ff == SEQ_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (move_a) begin
            a_valid_ff <= accept;
         end
         if (move_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (move_c) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < 4; j++) begin
            a_sum_ff[j] <= term_snap[2*j] + term_snap[2*j+1];
         end
         a_dst_ff  <= dst_snap;
         a_seg_ff  <= seg_end_w;
         a_last_ff <= last_w;
      end
      if (move_b && a_valid_ff) begin
         b_sum_ff[0] <= a_sum_ff[0] + a_sum_ff[1];
         b_sum_ff[1] <= a_sum_ff[2] + a_sum_ff[3];
         b_dst_ff    <= a_dst_ff;
         b_seg_ff    <= a_seg_ff;
         b_last_ff   <= a_last_ff;
      end
      if (move_c && b_valid_ff) begin
         c_src_ff  <= b_sum_ff[0] + b_sum_ff[1];
         c_dst_ff  <= b_dst_ff;
         c_seg_ff  <= b_seg_ff;
         c_last_ff <= b_last_ff;
      end
   end

   assign rsp_bus.valid       = c_valid_ff;
   assign rsp_bus.src_offset  = c_src_ff;
   assign rsp_bus.dst_offset  = c_dst_ff;
   assign rsp_bus.segment_end = c_seg_ff;
   assign rsp_bus.last        = c_last_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last_w |=> cnt_zero_w && dst_ff == '0)
      else $error("walk did not wrap to element zero after the last element");

   a_dst_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.restart && !last_w |=> dst_ff == $past(dst_ff) + OFFSET_WIDTH'(1))
      else $error("destination offset did not advance by one");

   a_block_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> !req_bus.ready)
      else $error("request taken while strides are being rebuilt");

   a_last_is_seg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last |-> rsp_bus.segment_end)
      else $error("final element not flagged as segment end");

endmodule

@@ verif/tb_timespace_to_depth_address_gen.sv @@
// Self-checking testbench for timespace_to_depth_address_gen: directed shape cases, then
// random walks under several idle and stall mixes, checked against an internal fold predictor.
// Depends on ttd_pkg, the channel interfaces in ttd_if and the design under test.

module tb_timespace_to_depth_address_gen;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFF_W          = 48;
   localparam int CNT_W          = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_CAP     = 100;

   localparam logic [ttd_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // Walk levels in destination order, channel fastest.
   localparam int WALK_CHAN   = 0;
   localparam int WALK_WFOLD  = 1;
   localparam int WALK_HFOLD  = 2;
   localparam int WALK_TFOLD  = 3;
   localparam int WALK_WOUT   = 4;
   localparam int WALK_HOUT   = 5;
   localparam int WALK_TOUT   = 6;
   localparam int WALK_BATCH  = 7;
   localparam int WALK_LEVELS = 8;

   typedef struct packed {
      logic [OFF_W-1:0] src_offset;
      logic [OFF_W-1:0] dst_offset;
      logic             segment_end;
      logic             last;
   } offset_pair_type;

   logic clock;
   logic reset;

   ttd_req_if                          req_bus ();
   ttd_rsp_if #(.OFFSET_WIDTH(OFF_W))  rsp_bus ();
   ttd_csr_if                          csr_bus ();

   timespace_to_depth_address_gen #(
      .OFFSET_WIDTH(OFF_W),
      .COUNT_WIDTH (CNT_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   offset_pair_type           pending_offsets[$];
   int unsigned               mismatch_count = 0;
   int unsigned               idle_cycles    = 0;
   int unsigned               req_idle_pct   = 0;
   int unsigned               rsp_stall_pct  = 0;

   // Predictor state: shape registers, walk position and destination counter.
   logic [ttd_pkg::CSR_DATA_W-1:0] shape_reg [ttd_pkg::CSR_BATCHES:ttd_pkg::CSR_SPACE_FOLD];
   longint unsigned           walk_pos [WALK_LEVELS];
   logic [OFF_W-1:0]          dst_next;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned eff_size(input logic [ttd_pkg::CSR_DATA_W-1:0] v);
      return (v == '0) ? 64'd1 : {48'd0, v};
   endfunction

   function automatic longint unsigned eff_fold(input logic [ttd_pkg::CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return 64'd1;
      end else if (v > 16) begin
         return 64'd16;
      end
      return {48'd0, v};
   endfunction

   function automatic void reset_model();
      foreach (shape_reg[i]) shape_reg[i] = 16'd1;
      foreach (walk_pos[i]) walk_pos[i] = 0;
      dst_next = '0;
   endfunction

   // Works out the offset pair for one transfer and advances the walk.
   function automatic offset_pair_type predict_offsets(input logic restart_bit);
      longint unsigned n [WALK_LEVELS];
      longint unsigned full_t, full_h, full_w, src;
      offset_pair_type r;
      bit              carry;

      n[WALK_CHAN]  = eff_size(shape_reg[ttd_pkg::CSR_CHANNELS]);
      n[WALK_WFOLD] = eff_fold(shape_reg[ttd_pkg::CSR_SPACE_FOLD]);
      n[WALK_HFOLD] = n[WALK_WFOLD];
      n[WALK_TFOLD] = eff_fold(shape_reg[ttd_pkg::CSR_TIME_FOLD]);
      n[WALK_WOUT]  = eff_size(shape_reg[ttd_pkg::CSR_OUT_WIDTH]);
      n[WALK_HOUT]  = eff_size(shape_reg[ttd_pkg::CSR_OUT_HEIGHT]);
      n[WALK_TOUT]  = eff_size(shape_reg[ttd_pkg::CSR_OUT_TIME]);
      n[WALK_BATCH] = eff_size(shape_reg[ttd_pkg::CSR_BATCHES]);

      if (restart_bit) begin
         foreach (walk_pos[i]) walk_pos[i] = 0;
         dst_next = '0;
      end

      full_t = n[WALK_TOUT] * n[WALK_TFOLD];
      full_h = n[WALK_HOUT] * n[WALK_HFOLD];
      full_w = n[WALK_WOUT] * n[WALK_WFOLD];
      src = walk_pos[WALK_BATCH] * full_t + walk_pos[WALK_TOUT] * n[WALK_TFOLD]
            + walk_pos[WALK_TFOLD];
      src = src * full_h + walk_pos[WALK_HOUT] * n[WALK_HFOLD] + walk_pos[WALK_HFOLD];
      src = src * full_w + walk_pos[WALK_WOUT] * n[WALK_WFOLD] + walk_pos[WALK_WFOLD];
      src = src * n[WALK_CHAN] + walk_pos[WALK_CHAN];

      r.src_offset  = OFF_W'(src);
      r.dst_offset  = dst_next;
      r.segment_end = (walk_pos[WALK_CHAN] + 1 >= n[WALK_CHAN]);
      r.last        = 1'b1;
      for (int i = 0; i < WALK_LEVELS; i++) begin
         if (walk_pos[i] + 1 < n[i]) r.last = 1'b0;
      end

      // A counter held past its size after a shape change counts as at its end.
      carry = 1'b1;
      for (int i = 0; i < WALK_LEVELS; i++) begin
         if (carry) begin
            if (walk_pos[i] + 1 >= n[i]) begin
               walk_pos[i] = 0;
            end else begin
               walk_pos[i] = walk_pos[i] + 1;
               carry = 1'b0;
            end
         end
      end

      dst_next = r.last ? '0 : dst_next + 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < REPORT_CAP) begin
         $display("%0t ns: %s differs, got %0h, expected %0h", $realtime, field, got, want);
      end
      mismatch_count++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      offset_pair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_offsets.size() == 0) begin
            report_mismatch("unexpected result, src_offset", 64'(rsp_bus.src_offset), 64'd0);
         end else begin
            want = pending_offsets.pop_front();
            if (rsp_bus.src_offset !== want.src_offset)
               report_mismatch("src_offset", 64'(rsp_bus.src_offset), 64'(want.src_offset));
            if (rsp_bus.dst_offset !== want.dst_offset)
               report_mismatch("dst_offset", 64'(rsp_bus.dst_offset), 64'(want.dst_offset));
            if (rsp_bus.segment_end !== want.segment_end)
               report_mismatch("segment_end", 64'(rsp_bus.segment_end),
                               64'(want.segment_end));
            if (rsp_bus.last !== want.last)
               report_mismatch("last", 64'(rsp_bus.last), 64'(want.last));
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_step(input logic restart_bit);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart_bit;
      do @(posedge clock); while (!req_bus.ready);
      pending_offsets.push_back(predict_offsets(restart_bit));
   endtask

   task automatic stop_sender();
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      do @(posedge clock); while (pending_offsets.size() != 0);
   endtask

   // Leaves valid high; end_csr lowers it after the last write of a group.
   task automatic write_csr(input logic [ttd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ttd_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         ttd_pkg::CSR_BATCHES, ttd_pkg::CSR_OUT_TIME, ttd_pkg::CSR_OUT_HEIGHT,
         ttd_pkg::CSR_OUT_WIDTH, ttd_pkg::CSR_CHANNELS: begin
            shape_reg[idx] = value;
         end
         ttd_pkg::CSR_TIME_FOLD, ttd_pkg::CSR_SPACE_FOLD: begin
            shape_reg[idx] = {11'd0, value[ttd_pkg::FOLD_W-1:0]};
         end
         default: begin
         end
      endcase
   endtask

   task automatic end_csr();
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_shape(input logic [15:0] b, input logic [15:0] t,
                              input logic [15:0] h, input logic [15:0] w,
                              input logic [15:0] c, input logic [15:0] tf,
                              input logic [15:0] sf);
      wait_for_drain();
      write_csr(ttd_pkg::CSR_BATCHES, b);
      write_csr(ttd_pkg::CSR_OUT_TIME, t);
      write_csr(ttd_pkg::CSR_OUT_HEIGHT, h);
      write_csr(ttd_pkg::CSR_OUT_WIDTH, w);
      write_csr(ttd_pkg::CSR_CHANNELS, c);
      write_csr(ttd_pkg::CSR_TIME_FOLD, tf);
      write_csr(ttd_pkg::CSR_SPACE_FOLD, sf);
      end_csr();
   endtask

   function automatic logic [15:0] pick_size(input int unsigned small_max);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 2) return 16'd0;
      if (r < 4) return 16'hFFFF;
      if (r < 6) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(1, small_max));
   endfunction

   function automatic logic [15:0] pick_fold();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 2) return 16'd0;
      if (r < 4) return 16'($urandom_range(17, 31));
      if (r < 6) return 16'd16;
      return 16'($urandom_range(1, (r < 20) ? 3 : 2));
   endfunction

   // Sends a run of steps; a restart now and then. Optionally stops midway
   // until every outstanding result has come back.
   task automatic run_walk(input int n, input int pause_at);
      for (int i = 0; i < n; i++) begin
         if (i == pause_at) begin
            stop_sender();
            wait_for_drain();
         end
         send_step((i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3));
      end
      stop_sender();
   endtask

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int n_items);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < 4; k++) begin
         write_shape(pick_size(2), pick_size(2), pick_size(2), pick_size(2), pick_size(3),
                     pick_fold(), pick_fold());
         run_walk(n_items / 4, (k == 0) ? n_items / 8 : -1);
      end
   endtask

   task automatic test_reset_defaults();
      send_step(1'b0);
      send_step(1'b1);
      send_step(1'b0);
      stop_sender();
   endtask

   // Zero sizes act as one; folds above sixteen act as sixteen.
   task automatic test_degenerate_sizes();
      write_shape(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_step(1'b0);
      send_step(1'b0);
      stop_sender();
      write_shape(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd31, 16'd17);
      send_step(1'b1);
      repeat (3) send_step(1'b0);
      stop_sender();
   endtask

   task automatic test_walk_wrap();
      write_shape(16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd1);
      send_step(1'b1);
      repeat (5) send_step(1'b0);
      stop_sender();
   endtask

   // Grows the shape under a batch count already past zero so the source offset
   // wraps, then shrinks it so held counters sit beyond their sizes. A write to the
   // unused index must change nothing.
   task automatic test_offset_wrap_and_stale_counters();
      write_shape(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      send_step(1'b1);
      send_step(1'b0);
      send_step(1'b0);
      stop_sender();
      write_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16, 16'd16);
      send_step(1'b0);
      send_step(1'b0);
      stop_sender();
      write_shape(16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      write_csr(CSR_SPARE, 16'hFFFF);
      end_csr();
      send_step(1'b0);
      send_step(1'b0);
      stop_sender();
   endtask

   task automatic test_random_no_idling();
      run_random_phase(0, 0, 460);
   endtask

   task automatic test_random_sender_idle();
      run_random_phase(77, 0, 460);
   endtask

   task automatic test_random_receiver_stall();
      run_random_phase(0, 77, 460);
   endtask

   task automatic test_random_both_idle();
      run_random_phase(21, 21, 460);
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.restart <= 1'b0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_degenerate_sizes();
      test_walk_wrap();
      test_offset_wrap_and_stale_counters();
      test_random_no_idling();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_offsets.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ timespace_to_depth_address_gen.f @@
rtl/ttd_pkg.sv
rtl/ttd_if.sv
rtl/ttd_serial_mul.sv
rtl/timespace_to_depth_address_gen.sv
verif/tb_timespace_to_depth_address_gen.sv
